[hw/rtl/tca_pkg.sv]
// shared types and constants for the triangle coverage and alpha blend block
`default_nettype none

package tca_pkg;

    localparam int COORD_W = 12;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = COORD_W + DIFF_W;
    localparam int DBL_W   = PROD_W + 2;
    localparam int AREA_W  = DBL_W - 1;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 21;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;

    localparam logic [IDX_W-1:0] REG_VERT0_X    = 3'd0;
    localparam logic [IDX_W-1:0] REG_VERT0_Y    = 3'd1;
    localparam logic [IDX_W-1:0] REG_VERT1_X    = 3'd2;
    localparam logic [IDX_W-1:0] REG_VERT1_Y    = 3'd3;
    localparam logic [IDX_W-1:0] REG_VERT2_X    = 3'd4;
    localparam logic [IDX_W-1:0] REG_VERT2_Y    = 3'd5;
    localparam logic [IDX_W-1:0] REG_FILL_COLOR = 3'd6;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

    // load enables of the three pipeline stages
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } pipe_en_t;

endpackage

`default_nettype wire

[hw/rtl/triangle_coverage_alpha_blend_core.sv]
// top level: triangle coverage test and alpha blend, four area and four blend lanes
`default_nettype none

// an accepted item moves through each stage register in turn before its result is valid
// throughput: one item per cycle; each stage holds its item while the next is full and stalled
// a stalled output still lets earlier empty stages take new items
// reset: synchronous active-low aresetn clears stage valids and config registers
// the configuration port is always ready

module triangle_coverage_alpha_blend_core
    import tca_pkg::*;
#(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    // configuration write channel
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [DATA_W-1:0]  cfg_data,
    // input item channel
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire logic [COORD_W-1:0] s_pix_x,
    input  wire logic [COORD_W-1:0] s_pix_y,
    input  wire logic [BYTE_W-1:0]  s_dst_blue,
    input  wire logic [BYTE_W-1:0]  s_dst_green,
    input  wire logic [BYTE_W-1:0]  s_dst_red,
    input  wire logic [BYTE_W-1:0]  s_dst_alpha,
    // result channel
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic                    m_inside_tri,
    output logic                    m_write_enable,
    output logic [ADDR_W-1:0]       m_pixel_address,
    output logic [BYTE_W-1:0]       m_out_blue,
    output logic [BYTE_W-1:0]       m_out_green,
    output logic [BYTE_W-1:0]       m_out_red,
    output logic [BYTE_W-1:0]       m_out_alpha
);

    // configuration registers
    logic signed [COORD_W-1:0] v0x_reg, v0y_reg, v1x_reg, v1y_reg, v2x_reg, v2y_reg;
    logic [DATA_W-1:0]         fill_reg;

    // stage valid flags
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    pipe_en_t pipe_en;

    logic signed [COORD_W-1:0] px, py;
    logic [AREA_W-1:0] area_tri, area_sub0, area_sub1, area_sub2;
    logic [BYTE_W-1:0] blue_b, green_b, red_b, alpha_b;
    logic [BYTE_W-1:0] fill_alpha;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0x_reg  <= '0;
            v0y_reg  <= '0;
            v1x_reg  <= '0;
            v1y_reg  <= '0;
            v2x_reg  <= '0;
            v2y_reg  <= '0;
            fill_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_VERT0_X:    v0x_reg  <= cfg_data[COORD_W-1:0];
                REG_VERT0_Y:    v0y_reg  <= cfg_data[COORD_W-1:0];
                REG_VERT1_X:    v1x_reg  <= cfg_data[COORD_W-1:0];
                REG_VERT1_Y:    v1y_reg  <= cfg_data[COORD_W-1:0];
                REG_VERT2_X:    v2x_reg  <= cfg_data[COORD_W-1:0];
                REG_VERT2_Y:    v2y_reg  <= cfg_data[COORD_W-1:0];
                REG_FILL_COLOR: fill_reg <= cfg_data;
                default: ; // indexes past the register list are dropped
            endcase
        end
    end

    // each stage loads when empty or when its item moves on
    assign rdy3 = !v3_reg || m_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_ready = rdy1;

    assign pipe_en.en1 = rdy1;
    assign pipe_en.en2 = rdy2;
    assign pipe_en.en3 = rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign m_valid = v3_reg;

    assign px = s_pix_x;
    assign py = s_pix_y;

    // whole triangle and the three sub-triangles with the pixel in place of one vertex
    tca_area_lane u_area_tri (
        .aclk(aclk), .pipe_en(pipe_en),
        .ax(v0x_reg), .ay(v0y_reg), .bx(v1x_reg), .by(v1y_reg),
        .cx(v2x_reg), .cy(v2y_reg), .area(area_tri)
    );

    tca_area_lane u_area_sub0 (
        .aclk(aclk), .pipe_en(pipe_en),
        .ax(px), .ay(py), .bx(v1x_reg), .by(v1y_reg),
        .cx(v2x_reg), .cy(v2y_reg), .area(area_sub0)
    );

    tca_area_lane u_area_sub1 (
        .aclk(aclk), .pipe_en(pipe_en),
        .ax(v0x_reg), .ay(v0y_reg), .bx(px), .by(py),
        .cx(v2x_reg), .cy(v2y_reg), .area(area_sub1)
    );

    tca_area_lane u_area_sub2 (
        .aclk(aclk), .pipe_en(pipe_en),
        .ax(v0x_reg), .ay(v0y_reg), .bx(v1x_reg), .by(v1y_reg),
        .cx(px), .cy(py), .area(area_sub2)
    );

    // blend weight is the fill colour's alpha byte, used on all four channels
    assign fill_alpha = fill_reg[4*BYTE_W-1:3*BYTE_W];

    tca_blend_lane u_blend_blue (
        .aclk(aclk), .pipe_en(pipe_en), .dst(s_dst_blue),
        .src(fill_reg[BYTE_W-1:0]), .alpha(fill_alpha), .blended(blue_b)
    );

    tca_blend_lane u_blend_green (
        .aclk(aclk), .pipe_en(pipe_en), .dst(s_dst_green),
        .src(fill_reg[2*BYTE_W-1:BYTE_W]), .alpha(fill_alpha), .blended(green_b)
    );

    tca_blend_lane u_blend_red (
        .aclk(aclk), .pipe_en(pipe_en), .dst(s_dst_red),
        .src(fill_reg[3*BYTE_W-1:2*BYTE_W]), .alpha(fill_alpha), .blended(red_b)
    );

    tca_blend_lane u_blend_alpha (
        .aclk(aclk), .pipe_en(pipe_en), .dst(s_dst_alpha),
        .src(fill_alpha), .alpha(fill_alpha), .blended(alpha_b)
    );

    // coverage decision, frame bounds, byte address and output register
    tca_merge #(
        .FRAME_WIDTH (FRAME_WIDTH),
        .FRAME_HEIGHT(FRAME_HEIGHT)
    ) u_merge (
        .aclk         (aclk),
        .pipe_en      (pipe_en),
        .pix_x        (s_pix_x),
        .pix_y        (s_pix_y),
        .area_tri     (area_tri),
        .area_sub0    (area_sub0),
        .area_sub1    (area_sub1),
        .area_sub2    (area_sub2),
        .blue_in      (blue_b),
        .green_in     (green_b),
        .red_in       (red_b),
        .alpha_in     (alpha_b),
        .inside_tri   (m_inside_tri),
        .write_enable (m_write_enable),
        .pixel_address(m_pixel_address),
        .out_blue     (m_out_blue),
        .out_green    (m_out_green),
        .out_red      (m_out_red),
        .out_alpha    (m_out_alpha)
    );

endmodule

`default_nettype wire

[hw/rtl/tca_area_lane.sv]
// one area lane: absolute half of a doubled triangle area over two stages
`default_nettype none

module tca_area_lane
    import tca_pkg::*;
(
    input  wire                         aclk,
    input  wire pipe_en_t               pipe_en,
    input  wire logic signed [COORD_W-1:0] ax,
    input  wire logic signed [COORD_W-1:0] ay,
    input  wire logic signed [COORD_W-1:0] bx,
    input  wire logic signed [COORD_W-1:0] by,
    input  wire logic signed [COORD_W-1:0] cx,
    input  wire logic signed [COORD_W-1:0] cy,
    output logic [AREA_W-1:0]           area
);

    logic signed [DIFF_W-1:0] d_bc, d_ca, d_ab;
    logic signed [PROD_W-1:0] p0_next, p1_next, p2_next;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [DBL_W-1:0]  d_sum, half;
    logic [AREA_W-1:0]        area_next, area_reg;

    assign d_bc = DIFF_W'(by) - DIFF_W'(cy);
    assign d_ca = DIFF_W'(cy) - DIFF_W'(ay);
    assign d_ab = DIFF_W'(ay) - DIFF_W'(by);

    assign p0_next = PROD_W'(ax) * PROD_W'(d_bc);
    assign p1_next = PROD_W'(bx) * PROD_W'(d_ca);
    assign p2_next = PROD_W'(cx) * PROD_W'(d_ab);

    always_ff @(posedge aclk) begin
        if (pipe_en.en1) begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    // halve with truncation toward zero, then magnitude
    always_comb begin
        d_sum = DBL_W'(p0_reg) + DBL_W'(p1_reg) + DBL_W'(p2_reg);
        half  = (d_sum + $signed({{(DBL_W-1){1'b0}}, d_sum[DBL_W-1]})) >>> 1;
        if (half[DBL_W-1]) begin
            area_next = AREA_W'(-half);
        end else begin
            area_next = half[AREA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en.en2) begin
            area_reg <= area_next;
        end
    end

    assign area = area_reg;

endmodule

`default_nettype wire

[hw/rtl/tca_blend_lane.sv]
// one colour channel blend: floor((dst*(255-a)+src*a)/255) over two stages
`default_nettype none

module tca_blend_lane
    import tca_pkg::*;
(
    input  wire                     aclk,
    input  wire pipe_en_t           pipe_en,
    input  wire logic [BYTE_W-1:0]  dst,
    input  wire logic [BYTE_W-1:0]  src,
    input  wire logic [BYTE_W-1:0]  alpha,
    output logic [BYTE_W-1:0]       blended
);

    logic [2*BYTE_W-1:0] pd_reg, ps_reg;
    logic [2*BYTE_W:0]   sum;
    logic [2*BYTE_W:0]   quot;
    logic [BYTE_W-1:0]   blended_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en.en1) begin
            pd_reg <= (2*BYTE_W)'(dst) * (2*BYTE_W)'(BYTE_MAX - alpha);
            ps_reg <= (2*BYTE_W)'(src) * (2*BYTE_W)'(alpha);
        end
    end

    // exact divide by 255 for sums below 2^16 - 1
    always_comb begin
        sum  = {1'b0, pd_reg} + {1'b0, ps_reg};
        quot = (sum + (sum >> BYTE_W) + (2*BYTE_W+1)'(1)) >> BYTE_W;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en.en2) begin
            blended_reg <= quot[BYTE_W-1:0];
        end
    end

    assign blended = blended_reg;

endmodule

`default_nettype wire

[hw/rtl/tca_merge.sv]
// merge stage: area comparison, bounds, address and the output register
`default_nettype none

module tca_merge
    import tca_pkg::*;
#(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  wire                         aclk,
    input  wire pipe_en_t               pipe_en,
    input  wire logic [COORD_W-1:0]     pix_x,
    input  wire logic [COORD_W-1:0]     pix_y,
    input  wire logic [AREA_W-1:0]      area_tri,
    input  wire logic [AREA_W-1:0]      area_sub0,
    input  wire logic [AREA_W-1:0]      area_sub1,
    input  wire logic [AREA_W-1:0]      area_sub2,
    input  wire logic [BYTE_W-1:0]      blue_in,
    input  wire logic [BYTE_W-1:0]      green_in,
    input  wire logic [BYTE_W-1:0]      red_in,
    input  wire logic [BYTE_W-1:0]      alpha_in,
    output logic                        inside_tri,
    output logic                        write_enable,
    output logic [ADDR_W-1:0]           pixel_address,
    output logic [BYTE_W-1:0]           out_blue,
    output logic [BYTE_W-1:0]           out_green,
    output logic [BYTE_W-1:0]           out_red,
    output logic [BYTE_W-1:0]           out_alpha
);

    localparam int MAG_W = COORD_W - 1;
    localparam int LIN_W = 2 * MAG_W;
    localparam logic [MAG_W-1:0] FW = MAG_W'(FRAME_WIDTH);
    localparam logic [MAG_W-1:0] FH = MAG_W'(FRAME_HEIGHT);

    logic              inb_next, inb1_reg, inb2_reg;
    logic [LIN_W-1:0]  row_reg;
    logic [MAG_W-1:0]  col_reg;
    logic [LIN_W-1:0]  lin_reg;
    logic [AREA_W+1:0] sub_sum;
    logic              inside_next, we_next;
    logic [ADDR_W-1:0] addr_next;

    logic              inside_reg, we_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [BYTE_W-1:0] blue_reg, green_reg, red_reg, alpha_reg;

    assign inb_next = !pix_x[COORD_W-1] && (pix_x[MAG_W-1:0] < FW) &&
                      !pix_y[COORD_W-1] && (pix_y[MAG_W-1:0] < FH);

    always_ff @(posedge aclk) begin
        if (pipe_en.en1) begin
            row_reg  <= LIN_W'(pix_y[MAG_W-1:0]) * LIN_W'(FW);
            col_reg  <= pix_x[MAG_W-1:0];
            inb1_reg <= inb_next;
        end
        if (pipe_en.en2) begin
            lin_reg  <= row_reg + LIN_W'(col_reg);
            inb2_reg <= inb1_reg;
        end
    end

    always_comb begin
        sub_sum     = (AREA_W+2)'(area_sub0) + (AREA_W+2)'(area_sub1) +
                      (AREA_W+2)'(area_sub2);
        inside_next = (sub_sum == (AREA_W+2)'(area_tri));
        we_next     = inside_next && inb2_reg;
        if (we_next) begin
            addr_next = {lin_reg[ADDR_W-3:0], 2'b00};
        end else begin
            addr_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en.en3) begin
            inside_reg <= inside_next;
            we_reg     <= we_next;
            addr_reg   <= addr_next;
            blue_reg   <= blue_in;
            green_reg  <= green_in;
            red_reg    <= red_in;
            alpha_reg  <= alpha_in;
        end
    end

    assign inside_tri    = inside_reg;
    assign write_enable  = we_reg;
    assign pixel_address = addr_reg;
    assign out_blue      = blue_reg;
    assign out_green     = green_reg;
    assign out_red       = red_reg;
    assign out_alpha     = alpha_reg;

endmodule

`default_nettype wire
